// ===== src/mciir_pkg.sv =====
package mciir_pkg;

  localparam int CHANNELS = 8;
  localparam int ORDER    = 4;

  // coefficient row per channel: b[0..ORDER] then a[0..ORDER-1]
  localparam int TAPS       = 2 * ORDER + 1;
  // history row per channel: x[n-1..n-ORDER] then y[n-1..n-ORDER]
  localparam int HTAPS      = 2 * ORDER;
  localparam int COEF_DEPTH = CHANNELS * TAPS;
  localparam int HIST_DEPTH = CHANNELS * HTAPS;
  localparam int COEF_AW    = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
  localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int K_W        = $clog2(TAPS + 1);

  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_NUM    = 2'd1;
  localparam logic [1:0] MODE_DEN    = 2'd2;

  localparam logic signed [63:0] ACC_MAX    = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] ACC_MIN    = 64'sh8000_0000_0000_0000;
  localparam logic signed [64:0] ROUND_HALF = 65'sh80_0000;

  typedef struct packed {
    logic [1:0]         mode;
    logic [2:0]         channel;
    logic [2:0]         tap;
    logic signed [31:0] value;
  } item_t;

  typedef struct packed {
    logic [2:0]         out_channel;
    logic signed [31:0] filtered;
    logic               clipped;
  } result_t;

endpackage

// ===== src/multichannel_iir_direct_form_one.sv =====
// channel   direction   handshake                     payload
// item      in          item_valid / item_ready       item_t   (mode, channel, tap, value)
// result    out         result_valid / result_ready   result_t (out_channel, filtered, clipped)
//
// a sample item walks its taps in S_RUN, rounds in S_ROUND and loads the
// result register from S_DONE; one shared 32x32 multiplier walks the channel's taps one per cycle
// coefficient writes and ignored items are taken without leaving the idle state
// synchronous reset clears control state and the per-entry valid bits of both memories
// the result register holds a finished item while the next item is taken; a sample that
// finishes while it is still full waits in its last state until the result is taken
module multichannel_iir_direct_form_one
  import mciir_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_ROUND = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;

  // coefficient and history memories
  logic [31:0]           coef_mem [COEF_DEPTH];
  logic [COEF_DEPTH-1:0] coef_vld;
  logic                  coef_we;
  logic [COEF_AW-1:0]    coef_waddr;
  logic [COEF_AW-1:0]    coef_raddr;
  logic [31:0]           coef_rd;
  logic                  coef_vld_rd;

  logic [31:0]           hist_mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] hist_vld;
  logic                  hist_we;
  logic [HIST_AW-1:0]    hist_waddr;
  logic [31:0]           hist_wdata;
  logic [HIST_AW-1:0]    hist_raddr;
  logic [31:0]           hist_rd;
  logic                  hist_vld_rd;

  // current item
  logic [2:0]         ch;
  logic signed [31:0] val;
  logic [COEF_AW-1:0] coef_base;
  logic [HIST_AW-1:0] hist_base;

  // tap sequencer and pipeline
  logic               iss_on;
  logic [K_W-1:0]     iss;
  logic               s1_valid;
  logic [K_W-1:0]     s1_k;
  logic               s2_valid;
  logic               s2_sub;
  logic               s2_last;
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic signed [63:0] acc_next;
  logic signed [64:0] sum_wide;
  logic signed [64:0] rnd_wide;

  logic signed [31:0] operand;
  logic signed [31:0] coefv;
  logic signed [39:0] shifted;
  logic               clip;
  logic signed [31:0] filtered_c;

  logic accept;
  logic ch_ok;
  logic out_free;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign ch_ok      = int'(item.channel) < CHANNELS;
  assign out_free   = !result_valid || result_ready;

  // coefficient writes come straight from the item
  always_comb begin
    coef_we    = 1'b0;
    coef_waddr = COEF_AW'(int'(item.channel) * TAPS + int'(item.tap));
    if (accept && ch_ok) begin
      if (item.mode == MODE_NUM && int'(item.tap) <= ORDER) begin
        coef_we = 1'b1;
      end else if (item.mode == MODE_DEN && int'(item.tap) < ORDER) begin
        coef_we    = 1'b1;
        coef_waddr = COEF_AW'(int'(item.channel) * TAPS + ORDER + 1 + int'(item.tap));
      end
    end
  end

  assign coef_raddr = coef_base + COEF_AW'(iss);
  assign hist_raddr = hist_base + HIST_AW'(iss) - HIST_AW'(1);

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= item.value;
    end
    coef_rd     <= coef_mem[coef_raddr];
    coef_vld_rd <= coef_vld[coef_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld <= '0;
    end else if (coef_we) begin
      coef_vld[coef_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    hist_rd     <= hist_mem[hist_raddr];
    hist_vld_rd <= hist_vld[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_vld <= '0;
    end else if (hist_we) begin
      hist_vld[hist_waddr] <= 1'b1;
    end
  end

  // entries never written read as zero
  assign operand = (s1_k == '0) ? val : (hist_vld_rd ? hist_rd : '0);
  assign coefv   = coef_vld_rd ? coef_rd : '0;

  // saturating accumulate
  always_comb begin
    if (s2_sub) begin
      sum_wide = {acc[63], acc} - {prod[63], prod};
    end else begin
      sum_wide = {acc[63], acc} + {prod[63], prod};
    end
    if (sum_wide[64] != sum_wide[63]) begin
      acc_next = sum_wide[64] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_next = sum_wide[63:0];
    end
  end

  assign rnd_wide = {acc[63], acc} + ROUND_HALF;

  // floor shift by 24, then clamp to 32 bits
  assign shifted    = acc[63:24];
  assign clip       = !((&shifted[39:31]) || !(|shifted[39:31]));
  assign filtered_c = clip ? (shifted[39] ? 32'sh8000_0000 : 32'sh7fff_ffff) : shifted[31:0];

  // history shift rides on the reads: the old x[k-1] or y[k-1] lands in slot k,
  // the newest sample goes in x[0] and the result in y[0] at the end
  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = hist_base + HIST_AW'(s1_k);
    hist_wdata = operand;
    priority if (state == S_DONE && out_free) begin
      hist_we    = 1'b1;
      hist_waddr = hist_base + HIST_AW'(ORDER);
      hist_wdata = filtered_c;
    end else if (s1_valid && s1_k != K_W'(ORDER) && s1_k != K_W'(HTAPS)) begin
      hist_we = 1'b1;
    end else begin
      hist_we = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      iss_on       <= 1'b0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid <= iss_on;
      s2_valid <= s1_valid;
      if (iss_on && iss == K_W'(HTAPS)) begin
        iss_on <= 1'b0;
      end
      if (state == S_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && ch_ok && item.mode == MODE_SAMPLE) begin
            state  <= S_RUN;
            iss_on <= 1'b1;
          end
        end
        S_RUN: begin
          if (s2_valid && s2_last) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      ch        <= item.channel;
      val       <= item.value;
      coef_base <= COEF_AW'(int'(item.channel) * TAPS);
      hist_base <= HIST_AW'(int'(item.channel) * HTAPS);
      iss       <= '0;
      acc       <= '0;
    end else begin
      if (iss_on) begin
        iss <= iss + K_W'(1);
      end
      if (s2_valid) begin
        acc <= acc_next;
      end else if (state == S_ROUND) begin
        acc <= rnd_wide[64] != rnd_wide[63] ? ACC_MAX : rnd_wide[63:0];
      end
    end
    s1_k    <= iss;
    prod    <= coefv * operand;
    s2_sub  <= s1_k > K_W'(ORDER);
    s2_last <= s1_k == K_W'(HTAPS);
    if (state == S_DONE && out_free) begin
      result.out_channel <= ch;
      result.filtered    <= filtered_c;
      result.clipped     <= clip;
    end
  end

  a_pipe_in_run: assert property (@(posedge clk) disable iff (rst)
    (s1_valid || s2_valid) |-> state == S_RUN)
    else $error("tap pipeline active outside run state");

  a_hist_in_row: assert property (@(posedge clk) disable iff (rst)
    hist_we |-> (hist_waddr >= hist_base &&
                 int'(hist_waddr) < int'(hist_base) + HTAPS))
    else $error("history write outside the channel row");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (result_valid && state == S_IDLE))
    else $error("finished sample did not reach the result register");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    item_ready |-> (!iss_on && !s1_valid && !s2_valid))
    else $error("item taken while taps still in flight");

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  import mciir_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PER_PHASE     = 366;
  localparam int SETTLE_CYCLES = 30;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE_Q24 = 32'sh0100_0000;
  localparam logic signed [31:0] HALF_LSB_Q24 = 32'sh0080_0000;
  localparam logic signed [63:0] OUT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] OUT_MIN = -64'sd2147483648;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  int send_idle = 0;
  int recv_stall = 0;
  bit hold_request = 1'b0;
  int cycle_count = 0;

  class iir_bank_tracker;
    logic signed [31:0] num_coef [CHANNELS][ORDER+1];
    logic signed [31:0] den_coef [CHANNELS][ORDER];
    logic signed [31:0] past_x [CHANNELS][ORDER];
    logic signed [31:0] past_y [CHANNELS][ORDER];
    result_t awaited_outputs[$];
    int errors, checked, clipped_seen, samples, coef_writes, ignored;

    function new();
      foreach (num_coef[c, k]) num_coef[c][k] = '0;
      foreach (den_coef[c, k]) den_coef[c][k] = '0;
      foreach (past_x[c, k]) begin
        past_x[c][k] = '0;
        past_y[c][k] = '0;
      end
    endfunction

    function logic signed [63:0] clamp_acc(logic signed [64:0] w);
      if (w[64] != w[63]) return w[64] ? ACC_MIN : ACC_MAX;
      return w[63:0];
    endfunction

    function logic signed [63:0] product(logic signed [31:0] a, logic signed [31:0] b);
      logic signed [63:0] wa, wb;
      wa = a;
      wb = b;
      return wa * wb;
    endfunction

    function result_t filter_sample(int ch, logic signed [31:0] x);
      logic signed [63:0] acc, term, r;
      result_t res;
      acc = '0;
      term = product(num_coef[ch][0], x);
      acc = clamp_acc({acc[63], acc} + {term[63], term});
      for (int k = 1; k <= ORDER; k++) begin
        term = product(num_coef[ch][k], past_x[ch][k-1]);
        acc = clamp_acc({acc[63], acc} + {term[63], term});
      end
      for (int k = 0; k < ORDER; k++) begin
        term = product(den_coef[ch][k], past_y[ch][k]);
        acc = clamp_acc({acc[63], acc} - {term[63], term});
      end
      // round half up, then arithmetic shift is a floor
      acc = clamp_acc({acc[63], acc} + ROUND_HALF);
      r = acc >>> 24;
      res.clipped = 1'b0;
      if (r > OUT_MAX) begin
        r = OUT_MAX;
        res.clipped = 1'b1;
      end else if (r < OUT_MIN) begin
        r = OUT_MIN;
        res.clipped = 1'b1;
      end
      for (int k = ORDER - 1; k > 0; k--) begin
        past_x[ch][k] = past_x[ch][k-1];
        past_y[ch][k] = past_y[ch][k-1];
      end
      past_x[ch][0] = x;
      past_y[ch][0] = r[31:0];
      res.out_channel = ch[2:0];
      res.filtered = r[31:0];
      return res;
    endfunction

    function void take_item(item_t it);
      if (it.channel >= CHANNELS) begin
        ignored++;
        return;
      end
      case (it.mode)
        MODE_SAMPLE: begin
          awaited_outputs.push_back(filter_sample(int'(it.channel), it.value));
          samples++;
        end
        MODE_NUM: begin
          if (it.tap <= ORDER) begin
            num_coef[it.channel][it.tap] = it.value;
            coef_writes++;
          end else begin
            ignored++;
          end
        end
        MODE_DEN: begin
          if (it.tap < ORDER) begin
            den_coef[it.channel][it.tap] = it.value;
            coef_writes++;
          end else begin
            ignored++;
          end
        end
        default: ignored++;
      endcase
    endfunction

    function void check_output(result_t got);
      result_t want;
      if (awaited_outputs.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected output: ch %0d filtered %0d clipped %0b",
                   got.out_channel, got.filtered, got.clipped);
        return;
      end
      want = awaited_outputs.pop_front();
      checked++;
      if (want.clipped) clipped_seen++;
      if (got.out_channel !== want.out_channel || got.filtered !== want.filtered ||
          got.clipped !== want.clipped) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: want ch %0d filt %0d clip %0b, got ch %0d filt %0d clip %0b",
                   want.out_channel, want.filtered, want.clipped,
                   got.out_channel, got.filtered, got.clipped);
      end
    endfunction
  endclass

  iir_bank_tracker bank = new();

  multichannel_iir_direct_form_one dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready) bank.take_item(item);
      if (result_valid && result_ready) bank.check_output(result);
    end
  end

  // output side: random back-pressure, plus a long hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      result_ready <= !rst && ($urandom_range(99) >= recv_stall);
    end
  end

  function automatic logic signed [31:0] pick_coef();
    int sel;
    int v;
    sel = $urandom_range(99);
    if (sel < 40) begin
      v = int'($urandom_range(1 << 23)) - (1 << 22);
    end else if (sel < 65) begin
      v = int'($urandom_range(1 << 25)) - (1 << 24);
    end else if (sel < 85) begin
      v = $urandom;
    end else begin
      case ($urandom_range(4))
        0: v = S32_MIN;
        1: v = S32_MAX;
        2: v = 0;
        3: v = -1;
        default: v = ONE_Q24;
      endcase
    end
    return v;
  endfunction

  function automatic logic signed [31:0] pick_sample();
    int sel;
    int v;
    sel = $urandom_range(99);
    if (sel < 50) begin
      v = int'($urandom_range(1 << 21)) - (1 << 20);
    end else if (sel < 80) begin
      v = $urandom;
    end else begin
      case ($urandom_range(5))
        0: v = S32_MIN;
        1: v = S32_MAX;
        2: v = 0;
        3: v = 1;
        4: v = -1;
        default: v = 32'sh0000_8000;
      endcase
    end
    return v;
  endfunction

  function automatic item_t make_random_item();
    item_t it;
    int sel;
    it.mode = MODE_SAMPLE;
    it.channel = 3'($urandom_range(7));
    it.tap = 3'($urandom_range(7));
    it.value = pick_sample();
    sel = $urandom_range(99);
    if (sel < 13) begin
      it.mode = MODE_NUM;
      it.tap = 3'($urandom_range(ORDER));
      it.value = pick_coef();
    end else if (sel < 24) begin
      it.mode = MODE_DEN;
      it.tap = 3'($urandom_range(ORDER - 1));
      it.value = pick_coef();
    end else if (sel < 28) begin
      it.value = $urandom;
      case ($urandom_range(2))
        0: it.mode = MODE_UNUSED;
        1: begin
          it.mode = MODE_NUM;
          it.tap = 3'($urandom_range(7, ORDER + 1));
        end
        default: begin
          it.mode = MODE_DEN;
          it.tap = 3'($urandom_range(7, ORDER));
        end
      endcase
    end
    return it;
  endfunction

  function automatic bit takes_effect(item_t it);
    if (it.channel >= CHANNELS) return 1'b0;
    if (it.mode == MODE_UNUSED) return 1'b0;
    if (it.mode == MODE_NUM && it.tap > ORDER) return 1'b0;
    if (it.mode == MODE_DEN && it.tap >= ORDER) return 1'b0;
    return 1'b1;
  endfunction

  task automatic offer(item_t it);
    if (send_idle != 0 && $urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
  endtask

  task automatic put(logic [1:0] m, int ch, int tp, logic signed [31:0] v);
    item_t it;
    it.mode = m;
    it.channel = ch[2:0];
    it.tap = tp[2:0];
    it.value = v;
    offer(it);
  endtask

  task automatic wait_outputs_done();
    while (bank.awaited_outputs.size() != 0) @(posedge clk);
  endtask

  int idle_of_phase [4] = '{0, 47, 0, 32};
  int stall_of_phase [4] = '{0, 0, 47, 32};

  initial begin
    item_t it;
    int n;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // all-zero coefficients give zero
    put(MODE_SAMPLE, 0, 0, S32_MAX);
    // extreme taps on one channel, stray tap field on samples
    put(MODE_NUM, 1, 0, S32_MAX);
    put(MODE_NUM, 1, 1, S32_MIN);
    put(MODE_NUM, 1, 2, ONE_Q24);
    put(MODE_NUM, 1, 3, -1);
    put(MODE_NUM, 1, 4, HALF_LSB_Q24);
    put(MODE_DEN, 1, 0, ONE_Q24);
    put(MODE_DEN, 1, 1, S32_MIN);
    put(MODE_DEN, 1, 2, S32_MAX);
    put(MODE_DEN, 1, 3, -HALF_LSB_Q24);
    // out-of-range taps and the unused mode must leave everything alone
    put(MODE_NUM, 1, ORDER + 1, 32'sh1234_5678);
    put(MODE_DEN, 1, ORDER, 32'sh1234_5678);
    put(MODE_UNUSED, 1, 0, S32_MAX);
    put(MODE_SAMPLE, 1, 7, S32_MAX);
    put(MODE_SAMPLE, 1, 7, S32_MIN);
    put(MODE_SAMPLE, 1, 0, -1);
    put(MODE_SAMPLE, 1, 0, 1);
    // accumulator runs into its positive limit
    put(MODE_NUM, 7, 0, S32_MIN);
    put(MODE_NUM, 7, 1, S32_MIN);
    put(MODE_NUM, 7, 2, S32_MIN);
    put(MODE_SAMPLE, 7, 0, S32_MIN);
    put(MODE_SAMPLE, 7, 0, S32_MIN);
    // rounding at exactly half an lsb, both signs
    put(MODE_NUM, 2, 0, 1);
    put(MODE_SAMPLE, 2, 0, HALF_LSB_Q24);
    put(MODE_SAMPLE, 2, 0, -HALF_LSB_Q24);
    put(MODE_SAMPLE, 2, 0, HALF_LSB_Q24 - 1);
    item_valid <= 1'b0;
    wait_outputs_done();

    for (int p = 0; p < 4; p++) begin
      @(negedge clk);
      send_idle = idle_of_phase[p];
      recv_stall = stall_of_phase[p];
      // output held off while items keep coming, so the input backs up
      if (p == 0) hold_request = 1'b1;
      @(posedge clk);
      n = 0;
      while (n < PER_PHASE) begin
        it = make_random_item();
        offer(it);
        if (takes_effect(it)) n++;
      end
      item_valid <= 1'b0;
      wait_outputs_done();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("filtered %0d samples across %0d channels with %0d tap loads and %0d ignored items",
             bank.samples, CHANNELS, bank.coef_writes, bank.ignored);
    $display("%0d outputs checked (%0d saturated) over four pacing phases and a %0d-cycle hold-off",
             bank.checked, bank.clipped_seen, HOLD_CYCLES);
    if (bank.errors == 0 && bank.awaited_outputs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d errors, %0d outputs still awaited", bank.errors, bank.awaited_outputs.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
